### src/hng_pkg.sv
// ----------------------------------------------------------------------------
// hng_pkg: shared types and constants
// Register indexes, widths and arithmetic helpers for the terrain normal block.
// ----------------------------------------------------------------------------
package hng_pkg;

  typedef enum logic [2:0] {
    REG_FREQ  = 3'd0,
    REG_AMP   = 3'd1,
    REG_BASE  = 3'd2,
    REG_UP    = 3'd3,
    REG_SPACE = 3'd4
  } reg_idx_e;

  localparam int unsigned SinA = 51472;
  localparam int unsigned SinB = 21024;
  localparam int unsigned SinC = 2320;
  localparam logic [21:0] InvTwoPi = 22'd2670177;
  localparam logic signed [23:0] HMax = 24'sd8388607;
  localparam logic signed [23:0] HMin = -24'sd8388608;

  typedef struct packed {
    logic [15:0]        freq;
    logic [15:0]        amp;
    logic signed [23:0] base;
    logic [15:0]        up;
    logic [15:0]        space;
  } cfg_t;

  typedef struct packed {
    logic        neg;
    logic [15:0] t;
    logic [15:0] t2;
    logic [16:0] yb;
  } sin_a_t;

  typedef struct packed {
    logic        neg;
    logic [15:0] t;
    logic [16:0] ya;
  } sin_b_t;

  // sine polynomial, first step: fold into one quadrant, square, inner term
  function automatic sin_a_t sin_fold(input logic [15:0] ph);
    logic [14:0] f;
    logic [31:0] p;
    logic [31:0] y1;
    sin_a_t      a;
    f     = ph[14] ? (15'h4000 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
    a.neg = ph[15];
    a.t   = {f, 1'b0};
    p     = a.t * a.t;
    a.t2  = p[30:15];
    y1    = 32'(SinC) * {16'd0, a.t2};
    a.yb  = 17'(SinB) - 17'(y1 >> 15);
    return a;
  endfunction

  // sine polynomial, second step: middle term
  function automatic sin_b_t sin_mid(input sin_a_t a);
    logic [33:0] y2;
    sin_b_t      b;
    y2    = {17'd0, a.yb} * {18'd0, a.t2};
    b.neg = a.neg;
    b.t   = a.t;
    b.ya  = 17'(SinA) - 17'(y2 >> 15);
    return b;
  endfunction

  // sine polynomial, last step: value in [-32768, 32768]
  function automatic logic signed [17:0] sin_last(input sin_b_t b);
    logic [33:0] y3;
    logic [16:0] y;
    y3 = {17'd0, b.ya} * {18'd0, b.t};
    y  = 17'(y3 >> 15);
    return b.neg ? -$signed({1'b0, y}) : $signed({1'b0, y});
  endfunction

endpackage

### src/heightfield_normal_generator.sv
// ----------------------------------------------------------------------------
// heightfield_normal_generator: terrain height and unit normal
// Five height evaluators, squared length, root and three dividers in a pipe.
// ----------------------------------------------------------------------------
// Pipeline: 80 register stages (7 height, 3 difference and sum, 30 root,
//   39 divide, 1 output).
// Throughput: one transaction per cycle; a stall freezes the whole pipe.
// Reset: valid bits clear, configuration registers return to their reset values.
module heightfield_normal_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // pos_x, pos_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // height, normal_x, normal_y, normal_z, pad
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  localparam int unsigned Depth = 80;

  hng_pkg::cfg_t cfg_q;
  logic en;
  logic [Depth-1:0] vld_q;
  logic signed [24:0] x0, z0;
  logic [15:0] d;
  logic signed [23:0] h [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{freq: 16'd1966, amp: 16'd2304, base: -24'sd3840,
                 up: 16'd512, space: 16'd256};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hng_pkg::REG_FREQ:  cfg_q.freq  <= cfg_data_i[15:0];
        hng_pkg::REG_AMP:   cfg_q.amp   <= cfg_data_i[15:0];
        hng_pkg::REG_BASE:  cfg_q.base  <= cfg_data_i;
        hng_pkg::REG_UP:    cfg_q.up    <= cfg_data_i[15:0];
        hng_pkg::REG_SPACE: cfg_q.space <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
  end

  assign x0 = 25'($signed(s_axis_tdata[23:0]));
  assign z0 = 25'($signed(s_axis_tdata[47:24]));
  assign d  = cfg_q.space;

  hng_height u_h0 (.clk_i, .en_i(en), .cfg_i(cfg_q), .x_i(x0), .z_i(z0), .h_o(h[0]));
  hng_height u_h1 (.clk_i, .en_i(en), .cfg_i(cfg_q), .x_i(x0 - 25'(d)), .z_i(z0),
                   .h_o(h[1]));
  hng_height u_h2 (.clk_i, .en_i(en), .cfg_i(cfg_q), .x_i(x0 + 25'(d)), .z_i(z0),
                   .h_o(h[2]));
  hng_height u_h3 (.clk_i, .en_i(en), .cfg_i(cfg_q), .x_i(x0), .z_i(z0 - 25'(d)),
                   .h_o(h[3]));
  hng_height u_h4 (.clk_i, .en_i(en), .cfg_i(cfg_q), .x_i(x0), .z_i(z0 + 25'(d)),
                   .h_o(h[4]));

  logic signed [25:0] nx_q, nz_q, ny_q;
  logic signed [23:0] hh_q;
  logic [51:0] sx_q, sz_q, sy_q;
  logic signed [25:0] nx2_q, nz2_q, ny2_q;
  logic signed [23:0] hh2_q;
  logic [59:0] sum_q;
  logic signed [25:0] nx3_q, nz3_q, ny3_q;
  logic signed [23:0] hh3_q;
  logic [29:0] len;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q  <= 26'(h[1]) - 26'(h[2]);
      nz_q  <= 26'(h[3]) - 26'(h[4]);
      ny_q  <= (cfg_q.up == 16'd0) ? 26'sd1 : $signed({10'd0, cfg_q.up});
      hh_q  <= h[0];
      sx_q  <= 52'(nx_q * nx_q);
      sz_q  <= 52'(nz_q * nz_q);
      sy_q  <= 52'(ny_q * ny_q);
      nx2_q <= nx_q; nz2_q <= nz_q; ny2_q <= ny_q; hh2_q <= hh_q;
      sum_q <= 60'(sx_q + sy_q + sz_q) << 10;
      nx3_q <= nx2_q; nz3_q <= nz2_q; ny3_q <= ny2_q; hh3_q <= hh2_q;
    end
  end

  hng_sqrt #(.Steps(30)) u_sqrt (.clk_i, .en_i(en), .v_i(sum_q), .r_o(len));

  logic signed [25:0] nxd_q [30], nzd_q [30], nyd_q [30];
  logic signed [23:0] hd_q [30];
  always_ff @(posedge clk_i) begin
    if (en) begin
      nxd_q[0] <= nx3_q; nzd_q[0] <= nz3_q; nyd_q[0] <= ny3_q; hd_q[0] <= hh3_q;
      for (int i = 1; i < 30; i++) begin
        nxd_q[i] <= nxd_q[i-1]; nzd_q[i] <= nzd_q[i-1];
        nyd_q[i] <= nyd_q[i-1]; hd_q[i]  <= hd_q[i-1];
      end
    end
  end

  logic signed [15:0] ux, uy, uz;
  hng_div u_dx (.clk_i, .en_i(en), .c_i(nxd_q[29]), .len_i(len), .lo_i(-17'sd32768),
                .r_o(ux));
  hng_div u_dy (.clk_i, .en_i(en), .c_i(nyd_q[29]), .len_i(len), .lo_i(17'sd0),
                .r_o(uy));
  hng_div u_dz (.clk_i, .en_i(en), .c_i(nzd_q[29]), .len_i(len), .lo_i(-17'sd32768),
                .r_o(uz));

  logic signed [23:0] hq_q [39];
  always_ff @(posedge clk_i) begin
    if (en) begin
      hq_q[0] <= hd_q[29];
      for (int i = 1; i < 39; i++) hq_q[i] <= hq_q[i-1];
    end
  end

  logic [71:0] out_q;
  always_ff @(posedge clk_i) begin
    if (en) out_q <= {1'b0, uz, uy[14:0], ux, hq_q[38]};
  end
  assign m_axis_tdata = out_q;

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready mismatch");
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[71])
    else $error("result pad bit set");
`endif

endmodule

### src/hng_height.sv
// ----------------------------------------------------------------------------
// hng_height: pipelined height evaluator
// Phase, sine/cosine, product and saturation over seven register stages.
// ----------------------------------------------------------------------------
module hng_height (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  hng_pkg::cfg_t        cfg_i,
  input  logic signed [24:0]   x_i,
  input  logic signed [24:0]   z_i,
  output logic signed [23:0]   h_o
);

  logic signed [41:0] rx_q, rz_q;
  logic signed [63:0] tx_d, tz_d;
  logic [15:0]        px_q, pz_q;
  hng_pkg::sin_a_t    sax_q, saz_q;
  hng_pkg::sin_b_t    sbx_q, sbz_q;
  logic signed [17:0] s_q, c_q;
  logic signed [35:0] sc_q;
  logic signed [52:0] v_d;
  logic signed [23:0] h_q;
  logic signed [24:0] sh_d;
  logic signed [25:0] hs_d;

  assign tx_d = 64'(rx_q) * $signed({1'b0, hng_pkg::InvTwoPi});
  assign tz_d = 64'(rz_q) * $signed({1'b0, hng_pkg::InvTwoPi});
  assign v_d  = 53'(sc_q) * $signed({1'b0, cfg_i.amp});
  assign sh_d = 25'((v_d + (53'sd1 <<< 29)) >>> 30);
  assign hs_d = 26'(sh_d) + 26'(cfg_i.base);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q  <= $signed({1'b0, cfg_i.freq}) * 42'(x_i);
      rz_q  <= $signed({1'b0, cfg_i.freq}) * 42'(z_i);
      px_q  <= tx_d[47:32];
      pz_q  <= tz_d[47:32] + 16'h4000;
      sax_q <= hng_pkg::sin_fold(px_q);
      saz_q <= hng_pkg::sin_fold(pz_q);
      sbx_q <= hng_pkg::sin_mid(sax_q);
      sbz_q <= hng_pkg::sin_mid(saz_q);
      s_q   <= hng_pkg::sin_last(sbx_q);
      c_q   <= hng_pkg::sin_last(sbz_q);
      sc_q  <= s_q * c_q;
      h_q   <= (hs_d > 26'(hng_pkg::HMax)) ? hng_pkg::HMax :
               (hs_d < 26'(hng_pkg::HMin)) ? hng_pkg::HMin : hs_d[23:0];
    end
  end

  assign h_o = h_q;

endmodule

### src/hng_sqrt.sv
// ----------------------------------------------------------------------------
// hng_sqrt: pipelined integer square root
// One result bit per stage, floor root of a 60-bit value.
// ----------------------------------------------------------------------------
module hng_sqrt #(
  parameter int unsigned Steps = 30
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [2*Steps-1:0]       v_i,
  output logic [Steps-1:0]         r_o
);

  logic [2*Steps-1:0] rem_q  [Steps+1];
  logic [Steps-1:0]   root_q [Steps+1];

  always_comb begin
    rem_q[0]  = v_i;
    root_q[0] = '0;
  end

  for (genvar i = 0; i < Steps; i++) begin : g_st
    logic [Steps+1:0]   trial;
    logic [Steps+1:0]   top;
    logic [2*Steps-1:0] rem_r;
    logic [Steps-1:0]   root_r;
    assign top   = (Steps+2)'(rem_q[i] >> (2*(Steps-1-i)));
    assign trial = {root_q[i], 2'b01};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (top >= trial) begin
          rem_r  <= rem_q[i] - ((2*Steps)'(trial) << (2*(Steps-1-i)));
          root_r <= {root_q[i][Steps-2:0], 1'b1};
        end else begin
          rem_r  <= rem_q[i];
          root_r <= {root_q[i][Steps-2:0], 1'b0};
        end
      end
    end
    assign rem_q[i+1]  = rem_r;
    assign root_q[i+1] = root_r;
  end

  assign r_o = root_q[Steps];

endmodule

### src/hng_div.sv
// ----------------------------------------------------------------------------
// hng_div: pipelined rounding divider
// Restoring division, one quotient bit per stage, then sign and clamp.
// ----------------------------------------------------------------------------
module hng_div #(
  parameter int unsigned QBits = 38
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [25:0]  c_i,
  input  logic [29:0]         len_i,
  input  logic signed [16:0]  lo_i,
  output logic signed [15:0]  r_o
);

  logic [QBits+29:0] num_d;
  logic [QBits+29:0] rem_q [QBits+1];
  logic [QBits-1:0]  quo_q [QBits+1];
  logic [29:0]       den_q [QBits+1];
  logic              neg_q [QBits+1];
  logic signed [16:0] lo_q [QBits+1];
  logic [25:0]       mag_d;
  logic signed [QBits:0] sq_d;

  assign mag_d = c_i[25] ? 26'(-c_i) : 26'(c_i);
  assign num_d = ((QBits+30)'(mag_d) << 20) + (QBits+30)'(len_i >> 1);

  always_comb begin
    rem_q[0] = '0;
    quo_q[0] = QBits'(num_d);
    den_q[0] = len_i;
    neg_q[0] = c_i[25];
    lo_q[0]  = lo_i;
  end

  for (genvar i = 0; i < QBits; i++) begin : g_st
    logic [QBits+29:0] sh;
    logic [QBits+29:0] rr;
    logic [QBits-1:0]  qr;
    logic [29:0]       dr;
    logic              nr;
    logic signed [16:0] lr;
    assign sh = {rem_q[i][QBits+28:0], quo_q[i][QBits-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dr <= den_q[i];
        nr <= neg_q[i];
        lr <= lo_q[i];
        if (sh >= (QBits+30)'(den_q[i])) begin
          rr <= sh - (QBits+30)'(den_q[i]);
          qr <= {quo_q[i][QBits-2:0], 1'b1};
        end else begin
          rr <= sh;
          qr <= {quo_q[i][QBits-2:0], 1'b0};
        end
      end
    end
    assign rem_q[i+1] = rr;
    assign quo_q[i+1] = qr;
    assign den_q[i+1] = dr;
    assign neg_q[i+1] = nr;
    assign lo_q[i+1]  = lr;
  end

  always_comb begin
    if (quo_q[QBits] > QBits'(32768)) sq_d = neg_q[QBits] ? -(QBits+1)'(32769)
                                                      : (QBits+1)'(32769);
    else sq_d = neg_q[QBits] ? -$signed({1'b0, quo_q[QBits]})
                             : $signed({1'b0, quo_q[QBits]});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o <= (sq_d > (QBits+1)'(32767)) ? 16'sd32767 :
             (sq_d < (QBits+1)'(lo_q[QBits])) ? 16'(lo_q[QBits]) : sq_d[15:0];
    end
  end

endmodule

### tb/heightfield_normal_generator_tb.sv
// ----------------------------------------------------------------------------
// heightfield_normal_generator_tb: self-checking testbench
// Streams ground coordinates through the block under bursty input and a
// stalling receiver, predicts height and unit normal per transaction in
// fixed point, and compares height and each normal component with the prediction.
// ----------------------------------------------------------------------------
module heightfield_normal_generator_tb;

  typedef struct {
    logic signed [23:0] height;
    logic signed [15:0] nx;
    logic [14:0]        ny;
    logic signed [15:0] nz;
  } surf_t;

  class surface_scoreboard;
    surf_t pending[$];
    int    errors;
    logic [15:0] freq, amp, up, space;
    logic signed [23:0] base;

    function new();
      errors = 0;
      freq = 16'd1966; amp = 16'd2304; base = -24'sd3840; up = 16'd512; space = 16'd256;
    endfunction

    function void write_reg(hng_pkg::reg_idx_e idx, logic [23:0] v);
      case (idx)
        hng_pkg::REG_FREQ:  freq = v[15:0];
        hng_pkg::REG_AMP:   amp = v[15:0];
        hng_pkg::REG_BASE:  base = v;
        hng_pkg::REG_UP:    up = v[15:0];
        hng_pkg::REG_SPACE: space = v[15:0];
        default: ;
      endcase
    endfunction

    function longint wave_sin(logic [15:0] ph);
      longint f, t, t2, y;
      f = longint'(ph[13:0]);
      if (ph[14]) f = 16384 - f;
      t = f * 2;
      t2 = (t * t) >>> 15;
      y = (2320 * t2) >>> 15;
      y = 21024 - y;
      y = (y * t2) >>> 15;
      y = 51472 - y;
      y = (y * t) >>> 15;
      return ph[15] ? -y : y;
    endfunction

    function logic [15:0] phase_of(longint c);
      longint turns;
      turns = longint'(freq) * c * 64'sd2670177;
      return turns[47:32];
    endfunction

    function longint height_at(longint x, longint z);
      longint s, c, v, h;
      s = wave_sin(phase_of(x));
      c = wave_sin(phase_of(z) + 16'h4000);
      v = s * c * longint'(amp) + (64'sd1 <<< 29);
      h = (v >>> 30) + longint'(base);
      if (h > 8388607) h = 8388607;
      if (h < -8388608) h = -8388608;
      return h;
    endfunction

    function longint isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unit_comp(longint c, longint unsigned len, longint lo);
      longint unsigned mag;
      longint r;
      mag = c < 0 ? -c : c;
      r = ((mag << 20) + (len >> 1)) / len;
      if (c < 0) r = -r;
      if (r > 32767) r = 32767;
      if (r < lo) r = lo;
      return r;
    endfunction

    function void note_input(logic [47:0] d);
      longint x, z, dd, nx, ny, nz;
      longint unsigned len;
      surf_t e;
      x = longint'($signed(d[23:0]));
      z = longint'($signed(d[47:24]));
      dd = longint'(space);
      nx = height_at(x - dd, z) - height_at(x + dd, z);
      nz = height_at(x, z - dd) - height_at(x, z + dd);
      ny = up != 0 ? longint'(up) : 1;
      len = isqrt((nx * nx + ny * ny + nz * nz) << 10);
      e.height = 24'(height_at(x, z));
      e.nx = 16'(unit_comp(nx, len, -32768));
      e.ny = 15'(unit_comp(ny, len, 0));
      e.nz = 16'(unit_comp(nz, len, -32768));
      pending.push_back(e);
    endfunction

    function void check_result(logic [71:0] d);
      surf_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[23:0] !== e.height) begin
        $display("%0t: height exp %0d got %0d", $time, e.height, $signed(d[23:0]));
        errors++;
      end
      if (d[39:24] !== e.nx) begin
        $display("%0t: normal_x exp %0d got %0d", $time, e.nx, $signed(d[39:24]));
        errors++;
      end
      if (d[54:40] !== e.ny) begin
        $display("%0t: normal_y exp %0d got %0d", $time, e.ny, d[54:40]);
        errors++;
      end
      if (d[70:55] !== e.nz) begin
        $display("%0t: normal_z exp %0d got %0d", $time, e.nz, $signed(d[70:55]));
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  surface_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;
  int  stall_mode = 0;

  always #5 clk_i = ~clk_i;

  heightfield_normal_generator u_dut (.*);

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    case (stall_mode)
      0: m_axis_tready <= !hold_off;
      1: m_axis_tready <= !hold_off && ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= !hold_off && ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
  end

  task automatic send_item(logic [23:0] x, logic [23:0] z);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drop_valid();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_cfg(hng_pkg::reg_idx_e idx, logic [23:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    sb.write_reg(idx, v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 24'($signed($urandom_range(0, 8192)) - 4096);
      1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_run(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && n > 0) begin
        send_item(rand_coord(), rand_coord());
        burst--; n--;
      end
      if ($urandom_range(0, 2) != 0) begin
        drop_valid();
        repeat ($urandom_range(0, 6)) @(posedge clk_i);
      end
    end
  endtask

  task automatic directed_run();
    send_item(24'h000000, 24'h000000);
    send_item(24'h7FFFFF, 24'h7FFFFF);
    send_item(24'h800000, 24'h800000);
    send_item(24'h7FFFFF, 24'h800000);
    send_item(24'h800000, 24'h7FFFFF);
    send_item(24'h000100, 24'hFFFF00);
    send_item(24'h555555, 24'hAAAAAA);
    send_item(24'hAAAAAA, 24'h555555);
    send_item(24'h000C80, 24'h001900);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_run();
    random_run(100);
    drain();

    // long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    fork
      random_run(150);
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain();

    write_cfg(hng_pkg::REG_FREQ, 24'hFFFF);
    write_cfg(hng_pkg::REG_AMP, 24'hFFFF);
    write_cfg(hng_pkg::REG_BASE, 24'h7FFFFF);
    write_cfg(hng_pkg::REG_UP, 24'h0000);
    write_cfg(hng_pkg::REG_SPACE, 24'h0000);
    directed_run();
    random_run(60);
    drain();

    write_cfg(hng_pkg::REG_BASE, 24'h800000);
    write_cfg(hng_pkg::REG_UP, 24'hFFFF);
    write_cfg(hng_pkg::REG_SPACE, 24'hFFFF);
    directed_run();
    random_run(60);
    drain();

    write_cfg(hng_pkg::REG_FREQ, 24'h0000);
    write_cfg(hng_pkg::REG_AMP, 24'h0000);
    write_cfg(hng_pkg::REG_BASE, 24'h000000);
    write_cfg(hng_pkg::REG_UP, 24'h0001);
    write_cfg(hng_pkg::REG_SPACE, 24'h0001);
    random_run(30);
    drain();

    repeat (5) begin
      write_cfg(hng_pkg::REG_FREQ, 24'($urandom_range(0, 65535)));
      write_cfg(hng_pkg::REG_AMP, 24'($urandom_range(0, 65535)));
      write_cfg(hng_pkg::REG_BASE, 24'($urandom));
      write_cfg(hng_pkg::REG_UP, 24'($urandom_range(0, 65535)));
      write_cfg(hng_pkg::REG_SPACE, 24'($urandom_range(0, 65535)));
      random_run(40);
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
